@@ design/twa_pkg.sv @@
`timescale 1ns / 1ps

package twa_pkg;

    localparam int TWA_WINDOW = 40;

    localparam int SAMPLE_W = 10;
    localparam int MEAN_W   = 18;
    localparam int PH_W     = 16;
    localparam int VREF_W   = 13;
    localparam int GAIN_W   = 14;
    localparam int OFFS_W   = 15;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_VREF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

    localparam logic [VREF_W-1:0] VREF_RESET   = 13'd5000;
    localparam logic [GAIN_W-1:0] GAIN_RESET   = 14'd3500;
    localparam logic [OFFS_W-1:0] OFFSET_RESET = 15'd0;

    // Trimmed sums fit in 16 bits for every window up to 64 entries.
    localparam int TRIM_W = 16;

    localparam int PROD_W       = MEAN_W + VREF_W + GAIN_W;
    localparam int SHIFT_Q8     = 18;
    localparam int MV_W         = PROD_W - SHIFT_Q8;
    localparam int MILLI_DIV    = 1000;
    localparam int MILLI_RECIP_W = 18;
    localparam logic [MILLI_RECIP_W-1:0] MILLI_RECIP =
        MILLI_RECIP_W'((longint'(1) << MV_W) / MILLI_DIV);

    typedef struct packed {
        logic              done;
        logic [TRIM_W-1:0] trimmed;
    } twa_scan_t;

    typedef struct packed {
        logic              valid;
        logic [MEAN_W-1:0] mean_q8;
        logic [PH_W-1:0]   ph_milli;
    } twa_res_t;

endpackage

@@ design/twa_ram.sv @@
`timescale 1ns / 1ps

module twa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 40
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/twa_scan.sv @@
`timescale 1ns / 1ps

module twa_scan #(
    parameter int WINDOW = twa_pkg::TWA_WINDOW
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [twa_pkg::SAMPLE_W-1:0]  sample,
    output twa_pkg::twa_scan_t            scan
);

    import twa_pkg::*;

    localparam int AW    = $clog2(WINDOW);
    localparam int SUM_W = $clog2(WINDOW * 1024);
    localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       idx_reg;
    logic                scan_reg;
    logic [WINDOW-1:0]   valid_reg;
    logic                rd_reg;
    logic                rd_first_reg;
    logic                rd_last_reg;
    logic                rd_valid_reg;
    logic                fin_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] lo_reg;
    logic [SAMPLE_W-1:0] hi_reg;

    logic [AW-1:0]       ram_addr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W-1:0] value;
    logic [SUM_W-1:0]    trimmed;

    assign ram_addr = scan_reg ? idx_reg : ptr_reg;

    twa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (start),
        .addr  (ram_addr),
        .wdata (sample),
        .rdata (ram_rdata)
    );

    // Entries never written since reset read as zero.
    assign value = rd_valid_reg ? ram_rdata : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            idx_reg   <= '0;
            scan_reg  <= 1'b0;
            valid_reg <= '0;
            rd_reg    <= 1'b0;
            fin_reg   <= 1'b0;
        end else begin
            rd_reg  <= scan_reg;
            fin_reg <= rd_reg && rd_last_reg;
            if (start) begin
                valid_reg[ptr_reg] <= 1'b1;
                ptr_reg  <= (ptr_reg == LAST) ? '0 : ptr_reg + 1'b1;
                scan_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (scan_reg) begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == LAST) begin
                    scan_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_first_reg <= (idx_reg == '0);
        rd_last_reg  <= (idx_reg == LAST);
        rd_valid_reg <= valid_reg[idx_reg];
        if (rd_reg) begin
            if (rd_first_reg) begin
                sum_reg <= SUM_W'(value);
                lo_reg  <= value;
                hi_reg  <= value;
            end else begin
                sum_reg <= sum_reg + SUM_W'(value);
                if (value < lo_reg) begin
                    lo_reg <= value;
                end
                if (value > hi_reg) begin
                    hi_reg <= value;
                end
            end
        end
    end

    assign trimmed      = sum_reg - SUM_W'(lo_reg) - SUM_W'(hi_reg);
    assign scan.done    = fin_reg;
    assign scan.trimmed = TRIM_W'(trimmed);

endmodule

@@ design/twa_arith.sv @@
`timescale 1ns / 1ps

module twa_arith #(
    parameter int WINDOW = twa_pkg::TWA_WINDOW
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  twa_pkg::twa_scan_t          scan,
    input  logic [twa_pkg::VREF_W-1:0]  vref_mv,
    input  logic [twa_pkg::GAIN_W-1:0]  ph_gain_milli,
    input  logic [twa_pkg::OFFS_W-1:0]  ph_offset_milli,
    input  logic                        take,
    output twa_pkg::twa_res_t           res
);

    import twa_pkg::*;

    localparam int N_W = TRIM_W + 8;
    localparam logic [N_W-1:0] DIV_K   = N_W'(WINDOW - 2);
    localparam logic [N_W-1:0] RECIP_N = N_W'((longint'(1) << N_W) / (WINDOW - 2));
    localparam logic [MV_W-1:0] MILLI_K = MV_W'(MILLI_DIV);
    localparam int PV_W  = MEAN_W + VREF_W;
    localparam int SUM_W = MEAN_W + 2;

    localparam logic [2:0] A_IDLE  = 3'd0;
    localparam logic [2:0] A_MUL_N = 3'd1;
    localparam logic [2:0] A_FIX_N = 3'd2;
    localparam logic [2:0] A_MUL_V = 3'd3;
    localparam logic [2:0] A_MUL_G = 3'd4;
    localparam logic [2:0] A_MUL_R = 3'd5;
    localparam logic [2:0] A_FIX_R = 3'd6;
    localparam logic [2:0] A_DONE  = 3'd7;

    logic [2:0]          state_reg;
    logic [N_W-1:0]      n_reg;
    logic [2*N_W-1:0]    prod_n_reg;
    logic [MEAN_W-1:0]   mean_reg;
    logic [PV_W-1:0]     pv_reg;
    logic [PROD_W-1:0]   pg_reg;
    logic [PROD_W-1:0]   pr_reg;
    logic [PH_W-1:0]     ph_reg;

    logic [MEAN_W-1:0]   q_est;
    logic [N_W-1:0]      q_rem;
    logic [MEAN_W-1:0]   mean_next;
    logic [MV_W-1:0]     mv;
    logic [MEAN_W-1:0]   q2_est;
    logic [MV_W-1:0]     q2_rem;
    logic [MEAN_W-1:0]   q2;
    logic signed [SUM_W-1:0] ph_sum;
    logic [PH_W-1:0]     ph_next;

    assign q_est     = prod_n_reg[N_W +: MEAN_W];
    assign q_rem     = n_reg - N_W'(N_W'(q_est) * DIV_K);
    assign mean_next = (q_rem >= DIV_K) ? q_est + 1'b1 : q_est;

    assign mv     = pg_reg[PROD_W-1:SHIFT_Q8];
    assign q2_est = pr_reg[MV_W +: MEAN_W];
    assign q2_rem = mv - MV_W'(MV_W'(q2_est) * MILLI_K);
    assign q2     = (q2_rem >= MILLI_K) ? q2_est + 1'b1 : q2_est;
    assign ph_sum = $signed({2'b00, q2})
                  + $signed({{(SUM_W-OFFS_W){ph_offset_milli[OFFS_W-1]}}, ph_offset_milli});

    always_comb begin
        if (ph_sum > $signed(SUM_W'(32767))) begin
            ph_next = 16'h7FFF;
        end else if (ph_sum < -$signed(SUM_W'(32768))) begin
            ph_next = 16'h8000;
        end else begin
            ph_next = ph_sum[PH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            unique case (state_reg)
                A_IDLE:  if (scan.done) state_reg <= A_MUL_N;
                A_MUL_N: state_reg <= A_FIX_N;
                A_FIX_N: state_reg <= A_MUL_V;
                A_MUL_V: state_reg <= A_MUL_G;
                A_MUL_G: state_reg <= A_MUL_R;
                A_MUL_R: state_reg <= A_FIX_R;
                A_FIX_R: state_reg <= A_DONE;
                A_DONE:  if (take) state_reg <= A_IDLE;
                default: state_reg <= A_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == A_IDLE && scan.done) begin
            n_reg <= {scan.trimmed, 8'h00};
        end
        if (state_reg == A_MUL_N) begin
            prod_n_reg <= (2*N_W)'(n_reg) * (2*N_W)'(RECIP_N);
        end
        if (state_reg == A_FIX_N) begin
            mean_reg <= mean_next;
        end
        if (state_reg == A_MUL_V) begin
            pv_reg <= PV_W'(mean_reg) * PV_W'(vref_mv);
        end
        if (state_reg == A_MUL_G) begin
            pg_reg <= PROD_W'(pv_reg) * PROD_W'(ph_gain_milli);
        end
        if (state_reg == A_MUL_R) begin
            pr_reg <= PROD_W'(mv) * PROD_W'(MILLI_RECIP);
        end
        if (state_reg == A_FIX_R) begin
            ph_reg <= ph_next;
        end
    end

    assign res.valid    = (state_reg == A_DONE);
    assign res.mean_q8  = mean_reg;
    assign res.ph_milli = ph_reg;

endmodule

@@ design/ph_trimmed_window_average.sv @@
`timescale 1ns / 1ps

// Trimmed moving-window average of pH probe samples.
// The slave channel takes one 10-bit converter sample per transaction. Each
// sample is written into a ring of WINDOW entries held in a single-port RAM;
// the ring is then read back one entry per cycle while a sum, a minimum and
// a maximum are accumulated. The sum less one minimum and one maximum is
// divided by WINDOW-2 and scaled to thousandths of pH in a short multiply
// sequence. The master channel returns one transaction per sample carrying
// the mean in Q8 counts and the saturated pH value.
// The result follows the ring read-back through the one RAM port and the
// arithmetic steps: reciprocal multiply and fix-up for the mean, Vref and
// gain multiplies, then milli reciprocal multiply and fix-up for pH. One
// sample is in flight at a time: s_tready is low until its result is taken.
// A finished result waits in the output register while the next sample is
// accepted; if the receiver stalls for longer, the arithmetic holds its
// result and s_tready stays low until the output register is free.
// Reset clears the ring valid flags, the write pointer and handshake state,
// and loads the default calibration. Configuration writes are taken on any
// cycle with cfg_wr_en high and must occur only while the block is idle.
module ph_trimmed_window_average #(
    parameter int WINDOW = twa_pkg::TWA_WINDOW
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [twa_pkg::S_TDATA_W-1:0]    s_tdata,   // [9:0] adc_sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [twa_pkg::M_TDATA_W-1:0]    m_tdata,   // [17:0] mean_q8, [33:18] ph_milli
    input  logic                             cfg_wr_en,
    input  logic [twa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [twa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import twa_pkg::*;

    logic [VREF_W-1:0] vref_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [OFFS_W-1:0] offset_reg;

    logic              busy_reg;
    logic              m_tvalid_reg;
    logic [MEAN_W-1:0] mean_out_reg;
    logic [PH_W-1:0]   ph_out_reg;

    logic              accept;
    logic              take;
    twa_scan_t         scan;
    twa_res_t          res;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign take     = res.valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vref_reg   <= VREF_RESET;
            gain_reg   <= GAIN_RESET;
            offset_reg <= OFFSET_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_VREF:   vref_reg   <= cfg_wdata[VREF_W-1:0];
                CFG_GAIN:   gain_reg   <= cfg_wdata[GAIN_W-1:0];
                CFG_OFFSET: offset_reg <= cfg_wdata[OFFS_W-1:0];
                default:    ;
            endcase
        end
    end

    twa_scan #(
        .WINDOW (WINDOW)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .sample  (s_tdata[SAMPLE_W-1:0]),
        .scan    (scan)
    );

    twa_arith #(
        .WINDOW (WINDOW)
    ) u_arith (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .scan            (scan),
        .vref_mv         (vref_reg),
        .ph_gain_milli   (gain_reg),
        .ph_offset_milli (offset_reg),
        .take            (take),
        .res             (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (take) begin
                busy_reg <= 1'b0;
            end
            if (take) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            mean_out_reg <= res.mean_q8;
            ph_out_reg   <= res.ph_milli;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-MEAN_W-PH_W){1'b0}}, ph_out_reg, mean_out_reg};

endmodule

@@ design/twa_checker.sv @@
`timescale 1ns / 1ps

module twa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [twa_pkg::M_TDATA_W-1:0] m_tdata
);

    import twa_pkg::*;

    // Only one sample is processed at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample accepted while another is in progress");

    // A new result frees the block for the next sample in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $rose(s_tready))
        else $error("result presented without completing a sample");

    // A stalled result transaction keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The trimmed mean never exceeds the largest sample in Q8.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[MEAN_W-1:0] <= 18'd261888)
        else $error("mean out of range");

endmodule

bind ph_trimmed_window_average twa_checker u_twa_checker (.*);
